### hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the frame parser.
// Each macro checks a property on the rising clock edge and is disabled
// while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### hdl/scfp_pkg.sv
`timescale 1ns / 1ps

package scfp_pkg;

    // Frame delimiters and payload lengths.
    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] TAIL_BYTE = 8'hFE;
    localparam logic [2:0] PAIR_LEN  = 3'd5;
    localparam logic [2:0] SHORT_LEN = 3'd2;

    // Valve payload bytes: the expected first byte and the second bytes that carry a command.
    localparam logic [7:0] VALVE_OPEN_BYTE  = 8'h01;
    localparam logic [7:0] VALVE_CLOSE_BYTE = 8'h00;
    localparam logic [7:0] VALVE_FIRST_BYTE = 8'h00;

    // APB port widths and configuration register reset values.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [7:0] RST_REJECTED_SOURCE = 8'd0;
    localparam logic [7:0] RST_PAIR_CODE       = 8'd1;
    localparam logic [7:0] RST_VALVE_CODE      = 8'd3;
    localparam logic [7:0] RST_CONNECT_CODE    = 8'd4;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_REJECTED_SOURCE = 2'd0,
        REG_PAIR_CODE       = 2'd1,
        REG_VALVE_CODE      = 2'd2,
        REG_CONNECT_CODE    = 2'd3
    } t_reg_idx;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_SRC  = 3'd1,
        PH_FUNC = 3'd2,
        PH_DATA = 3'd3,
        PH_TAIL = 3'd4
    } t_phase;

    // Kind of frame being parsed.
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PAIR    = 2'd1,
        KIND_VALVE   = 2'd2,
        KIND_CONNECT = 2'd3
    } t_kind;

    // Event codes on the result word.
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_OPEN  = 2'd1,
        EV_CLOSE = 2'd2,
        EV_PAIR  = 2'd3
    } t_event;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] rejected_source;
        logic [7:0] pair_code;
        logic [7:0] valve_code;
        logic [7:0] connect_code;
    } t_cfg;

    // Input word: one received byte with the pairing flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       pairing_mode;
    } t_in_word;

    // Result word: one event per received byte.
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] paired_address;
    } t_out_word;

endpackage

### hdl/scfp_cfg_regs.sv
`timescale 1ns / 1ps

module scfp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scfp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [scfp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [scfp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output scfp_pkg::t_cfg                      o_cfg
);
    import scfp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic [7:0] w_rd_byte;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rejected_source <= RST_REJECTED_SOURCE;
            r_cfg.pair_code       <= RST_PAIR_CODE;
            r_cfg.valve_code      <= RST_VALVE_CODE;
            r_cfg.connect_code    <= RST_CONNECT_CODE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_REJECTED_SOURCE: r_cfg.rejected_source <= pwdata[7:0];
                REG_PAIR_CODE:       r_cfg.pair_code       <= pwdata[7:0];
                REG_VALVE_CODE:      r_cfg.valve_code      <= pwdata[7:0];
                REG_CONNECT_CODE:    r_cfg.connect_code    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        unique case (w_idx)
            REG_REJECTED_SOURCE: w_rd_byte = r_cfg.rejected_source;
            REG_PAIR_CODE:       w_rd_byte = r_cfg.pair_code;
            REG_VALVE_CODE:      w_rd_byte = r_cfg.valve_code;
            REG_CONNECT_CODE:    w_rd_byte = r_cfg.connect_code;
            default:             w_rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-8){1'b0}}, w_rd_byte};

endmodule

### hdl/scfp_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scfp_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  scfp_pkg::t_in_word    i_word,
    input  scfp_pkg::t_cfg        i_cfg,
    output scfp_pkg::t_out_word   o_result
);
    import scfp_pkg::*;

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [2:0]  r_count, n_count;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_second, n_second;
    logic [15:0] r_addr, n_addr;

    t_kind       w_class;
    logic [2:0]  w_len;
    logic [2:0]  w_count_inc;
    logic [15:0] w_addr_next;
    logic [7:0]  w_byte;

    assign w_byte = i_word.rx_byte;

    // Function code lookup; earlier codes win when they coincide.
    always_comb begin
        priority if (w_byte == i_cfg.pair_code) begin
            w_class = KIND_PAIR;
        end else if (w_byte == i_cfg.valve_code) begin
            w_class = KIND_VALVE;
        end else if (w_byte == i_cfg.connect_code) begin
            w_class = KIND_CONNECT;
        end else begin
            w_class = KIND_NONE;
        end
    end

    // Payload length, count step and decimal fold (addr * 10 + byte).
    assign w_len       = (r_kind == KIND_PAIR) ? PAIR_LEN : SHORT_LEN;
    assign w_count_inc = r_count + 3'd1;
    assign w_addr_next = (r_addr << 3) + (r_addr << 1) + {8'd0, w_byte};

    // Next state and result for the current byte.
    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_count  = r_count;
        n_first  = r_first;
        n_second = r_second;
        n_addr   = r_addr;
        o_result.event_kind     = EV_NONE;
        o_result.paired_address = 16'd0;

        unique case (r_phase)
            PH_HDR: begin
                if (w_byte == HDR_BYTE) begin
                    n_phase = PH_SRC;
                end
            end
            PH_SRC: begin
                n_phase = (w_byte == i_cfg.rejected_source) ? PH_HDR : PH_FUNC;
            end
            PH_FUNC: begin
                if (w_class == KIND_NONE) begin
                    n_phase = PH_HDR;
                end else begin
                    n_kind  = w_class;
                    n_count = 3'd0;
                    n_addr  = 16'd0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_count == 3'd0) begin
                    n_first = w_byte;
                end else if (r_count == 3'd1) begin
                    n_second = w_byte;
                end
                n_addr  = w_addr_next;
                n_count = w_count_inc;
                if (w_count_inc >= w_len) begin
                    n_phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                if (w_byte == TAIL_BYTE) begin
                    if (r_kind == KIND_VALVE) begin
                        if (r_first == VALVE_FIRST_BYTE &&
                            r_second == VALVE_OPEN_BYTE) begin
                            o_result.event_kind = EV_OPEN;
                        end else if (r_first == VALVE_FIRST_BYTE &&
                                     r_second == VALVE_CLOSE_BYTE) begin
                            o_result.event_kind = EV_CLOSE;
                        end
                    end else if (r_kind == KIND_PAIR && i_word.pairing_mode) begin
                        o_result.event_kind     = EV_PAIR;
                        o_result.paired_address = r_addr;
                    end
                end
                n_phase = PH_HDR;
            end
            default: begin
                n_phase = PH_HDR;
            end
        endcase
    end

    // Control state, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_kind  <= KIND_NONE;
            r_count <= 3'd0;
            r_addr  <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_count <= n_count;
            r_addr  <= n_addr;
        end
    end

    // Valve payload bytes, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    // A processed tail byte always sends the parser back to the header hunt.
    `ASSERT_PROP(a_tail_returns, i_clk, i_rst_n,
        (i_step && r_phase == PH_TAIL) |=> (r_phase == PH_HDR))

endmodule

### hdl/serial_command_frame_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Serial command frame parser.
// Input channel: i_valid / o_stall carry one word per received byte, holding
// the byte and the pairing flag; a word is taken when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall carry exactly one result
// word per input word, with the event code and the paired address.
// The word is captured in the input register; the parser then updates its
// state and writes the result register when the word advances.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// can still take one more word; o_stall rises only when both are full.
// The APB port writes the rejected source and the three function codes at
// byte addresses 0, 4, 8 and 12; pready is always high.
// Reset (synchronous, active low) empties both registers, returns the parser
// to the header hunt and restores the register defaults.
module serial_command_frame_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  scfp_pkg::t_in_word                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output scfp_pkg::t_out_word                 o_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scfp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [scfp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [scfp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import scfp_pkg::*;

    t_cfg      w_cfg;
    t_out_word w_result;
    logic      w_take;
    logic      w_adv;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    scfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    scfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_word   (r_in_word),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Handshake: a word moves on when the result register is free or draining.
    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;
    assign w_take  = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_word <= i_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= w_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_word;

    // Only a pairing event carries an address.
    `ASSERT_PROP(a_addr_only_on_pair, i_clk, i_rst_n,
        (o_valid && o_data.event_kind != EV_PAIR) |-> (o_data.paired_address == 16'd0))

    // Both registers full and the receiver stalled must stall the sender.
    `ASSERT_PROP(a_full_stalls, i_clk, i_rst_n,
        (r_in_valid && r_out_valid && i_stall) |-> o_stall)

    // A buffered word with a free result register reaches the output next cycle.
    `ASSERT_PROP(a_word_advances, i_clk, i_rst_n,
        (r_in_valid && !r_out_valid) |=> r_out_valid)

endmodule
